### src/quintic_trajectory_generator_unit_assert.svh
// Assertion macros for the quintic trajectory generator.
// Expects clk and rst_n in the including module's scope.
`ifndef QUINTIC_TRAJECTORY_GENERATOR_UNIT_ASSERT_SVH
`define QUINTIC_TRAJECTORY_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define QTG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qtg assertion failed");

// Next-cycle implication.
`define QTG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qtg assertion failed");

`endif

### src/qtg_pkg.sv
// Package for the quintic trajectory generator: command/status types,
// codes and saturating fixed-point helpers. No dependencies.
`default_nettype none
package qtg_pkg;

  localparam int COEFF_FRAC_BITS = 32;
  localparam int EXTRA_BITS      = COEFF_FRAC_BITS - 16;

  localparam logic [15:0] PERIOD_RESET = 16'd66;

  // Horner pass kinds; the code is also the lowest coefficient index used
  localparam logic [1:0] KIND_POSE = 2'd0;
  localparam logic [1:0] KIND_VEL  = 2'd1;
  localparam logic [1:0] KIND_ACC  = 2'd2;

  localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic       capture;
    logic       decide;
    logic       solve_init;
    logic       div_start;
    logic       div_num;     // 1: fresh numerator, 0: running value
    logic       add_term;
    logic       term_b;      // acceleration term instead of velocity term
    logic       store_coef;
    logic       run;
    logic       ev_load;
    logic       ev_mul;
    logic       ev_add;
    logic       ev_store;
    logic       out_load;
    logic [2:0] k;
    logic [1:0] kind;
  } qtg_cmd_t;

  typedef struct packed {
    logic hold;
    logic need_solve;
    logic same_t;
    logic in_range;
    logic div_done;
    logic mul_done;
  } qtg_sts_t;

  function automatic logic [63:0] magn(input logic signed [63:0] x);
    logic [63:0] r;
    r = x[63] ? (64'd0 - x) : x;
    return r;
  endfunction

  function automatic logic signed [63:0] from_mag(input logic neg, input logic ovf,
                                                   input logic [63:0] m);
    logic signed [63:0] r;
    if (neg) begin
      r = (ovf || m[63]) ? MIN64 : -$signed(m);
    end else begin
      r = (ovf || m[63]) ? MAX64 : $signed(m);
    end
    return r;
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic [64:0] s;
    logic signed [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r = s[64] ? MIN64 : MAX64;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  // coefficient times a small unsigned factor, saturated
  function automatic logic signed [63:0] sat_mul_k(input logic signed [63:0] c,
                                                    input logic [4:0] f);
    logic signed [69:0] p;
    logic signed [63:0] r;
    p = $signed({{6{c[63]}}, c}) * $signed({65'd0, f});
    if ((p[69:63] == 7'h00) || (p[69:63] == 7'h7F)) begin
      r = p[63:0];
    end else begin
      r = p[69] ? MIN64 : MAX64;
    end
    return r;
  endfunction

  // drop the extra fraction bits toward zero, saturate to 32 bits
  function automatic logic signed [31:0] narrow32(input logic signed [63:0] x);
    logic [63:0] m;
    logic signed [31:0] r;
    m = magn(x) >> EXTRA_BITS;
    if (x[63]) begin
      r = (m > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
    end else begin
      r = (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
    end
    return r;
  endfunction

  // derivative weight of coefficient k for a pass kind
  function automatic logic [4:0] fac(input logic [1:0] kind, input logic [2:0] k);
    logic [4:0] r;
    unique case (kind)
      KIND_POSE: r = 5'd1;
      KIND_VEL:  r = {2'b00, k};
      default:   r = {2'b00, k} * {2'b00, k - 3'd1};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### src/qtg_div.sv
// Sequential signed divider: (|num| << sh) / |den|, 4 quotient bits per cycle,
// toward zero, saturated to 64 bits. Depends on qtg_pkg.
`default_nettype none
module qtg_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] num,
  input  wire logic               sh_wide,
  input  wire logic signed [32:0] den,
  output logic                    done,
  output logic signed [63:0]      quo
);

  logic         busy_r, fin_r;
  logic [4:0]   cnt_r;
  logic [127:0] dvd_r, dvd_nxt;
  logic [32:0]  d_r;
  logic [33:0]  rem_r, rem_nxt;
  logic [63:0]  q_r, q_nxt;
  logic         ovf_r, ovf_nxt;
  logic         neg_r;
  logic [63:0]  num_mag;

  assign num_mag = qtg_pkg::magn(num);

  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    ovf_nxt = ovf_r;
    dvd_nxt = dvd_r;
    for (int i = 0; i < 4; i++) begin
      rem_nxt = {rem_nxt[32:0], dvd_nxt[127]};
      dvd_nxt = {dvd_nxt[126:0], 1'b0};
      ovf_nxt = ovf_nxt | q_nxt[63];
      if (rem_nxt >= {1'b0, d_r}) begin
        rem_nxt = rem_nxt - {1'b0, d_r};
        q_nxt   = {q_nxt[62:0], 1'b1};
      end else begin
        q_nxt   = {q_nxt[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= sh_wide ? ({64'd0, num_mag} << qtg_pkg::COEFF_FRAC_BITS)
                       : ({64'd0, num_mag} << 16);
      d_r   <= den[32] ? (33'd0 - den) : den;
      neg_r <= num[63] ^ den[32];
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign done = fin_r;
  assign quo  = qtg_pkg::from_mag(neg_r, ovf_r, q_r);

endmodule
`default_nettype wire

### src/qtg_mul.sv
// Sequential signed multiplier: (a * b) >> 16 toward zero, saturated, using
// one 32x32 multiplier on the low, then the high half of a. Depends on qtg_pkg.
`default_nettype none
module qtg_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [32:0] b,
  output logic                    done,
  output logic signed [63:0]      prod
);

  logic [1:0]  ph_r;
  logic        done_r;
  logic [63:0] am_r;
  logic [31:0] bm_r;
  logic        neg_r;
  logic [63:0] plo_r, phi_r;
  logic signed [63:0] q_r;
  logic [32:0] b_mag;
  logic [31:0] mul_in;
  logic [63:0] mul_out;
  logic [95:0] full, shifted;

  assign b_mag   = b[32] ? (33'd0 - b) : b;
  assign mul_in  = (ph_r == 2'd1) ? am_r[31:0] : am_r[63:32];
  assign mul_out = {32'd0, mul_in} * {32'd0, bm_r};
  assign full    = {phi_r, 32'd0} + {32'd0, plo_r};
  assign shifted = full >> 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ph_r <= 2'd1;
      end else if (ph_r != 2'd0) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am_r  <= qtg_pkg::magn(a);
      bm_r  <= b_mag[31:0];
      neg_r <= a[63] ^ b[32];
    end
    if (ph_r == 2'd1) plo_r <= mul_out;
    if (ph_r == 2'd2) phi_r <= mul_out;
    if (ph_r == 2'd3) q_r <= qtg_pkg::from_mag(neg_r, |shifted[95:64], shifted[63:0]);
  end

  assign done = done_r;
  assign prod = q_r;

endmodule
`default_nettype wire

### src/qtg_dp.sv
// Datapath of the quintic trajectory generator: state, coefficients, solve
// and evaluation arithmetic. Depends on qtg_pkg, qtg_div, qtg_mul.
`default_nettype none
module qtg_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire qtg_pkg::qtg_cmd_t   cmd,
  output qtg_pkg::qtg_sts_t        sts,
  input  wire logic signed [31:0]  in_target_pose,
  input  wire logic signed [31:0]  in_target_velocity,
  input  wire logic signed [31:0]  in_target_accel,
  input  wire logic [31:0]         in_start_time,
  input  wire logic [31:0]         in_end_time,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_control_period,
  output logic signed [31:0]       out_pose_out,
  output logic signed [31:0]       out_velocity_out,
  output logic signed [31:0]       out_accel_out,
  output logic                     out_moving,
  output logic [31:0]              out_elapsed_out
);

  localparam int EB = qtg_pkg::EXTRA_BITS;

  logic [15:0]        period_r;
  logic signed [31:0] pose_r, vel_r, acc_r;
  logic [31:0]        elapsed_r;
  logic               moving_r;
  logic signed [31:0] goal_pose_r, goal_vel_r;
  logic [31:0]        goal_time_r;
  logic signed [63:0] coef_r [6];
  logic [31:0]        origin_r;

  logic signed [31:0] p1_r, v1_r, a1_r;
  logic [31:0]        t0_r, tf_r;
  logic signed [63:0] x_r, hacc_r, w_r;

  logic               changed;
  logic [31:0]        el0;
  logic [32:0]        esum;
  logic signed [32:0] h_w, t_w, tau_w;
  logic signed [63:0] hx, v0x, v1x, a0x, a1x;
  logic signed [63:0] nsel, tm_a, tm_b, div_num_w, div_q, mul_q, coef_sel, weight;
  logic               div_done, mul_done;

  assign changed = (p1_r != goal_pose_r) || (v1_r != goal_vel_r) || (tf_r != goal_time_r);
  assign el0     = changed ? 32'd0 : elapsed_r;
  assign esum    = {1'b0, elapsed_r} + {17'd0, period_r};
  assign h_w     = {p1_r[31], p1_r} - {pose_r[31], pose_r};
  assign t_w     = {1'b0, tf_r} - {1'b0, t0_r};
  assign tau_w   = {1'b0, elapsed_r} - {1'b0, origin_r};

  assign hx  = {{31{h_w[32]}}, h_w};
  assign v0x = {{32{vel_r[31]}}, vel_r};
  assign v1x = {{32{v1_r[31]}}, v1_r};
  assign a0x = {{32{acc_r[31]}}, acc_r};
  assign a1x = {{32{a1_r[31]}}, a1_r};

  // numerator and correction terms of the coefficient being solved
  always_comb begin
    unique case (cmd.k)
      3'd3: begin
        nsel = hx * 64'sd10;
        tm_a = -((v1x * 64'sd4 + v0x * 64'sd6) <<< EB);
        tm_b = -((a0x * 64'sd3 - a1x) <<< (EB - 1));
      end
      3'd4: begin
        nsel = hx * -64'sd15;
        tm_a = (v1x * 64'sd7 + v0x * 64'sd8) <<< EB;
        tm_b = (a0x * 64'sd3 - a1x * 64'sd2) <<< (EB - 1);
      end
      3'd5: begin
        nsel = hx * 64'sd6;
        tm_a = -(((v1x + v0x) * 64'sd3) <<< EB);
        tm_b = -((a0x - a1x) <<< (EB - 1));
      end
      default: begin
        nsel = '0;
        tm_a = '0;
        tm_b = '0;
      end
    endcase
  end

  assign div_num_w = cmd.div_num ? nsel : x_r;
  assign coef_sel  = coef_r[cmd.k];
  assign weight    = qtg_pkg::sat_mul_k(coef_sel, qtg_pkg::fac(cmd.kind, cmd.k));

  qtg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .num     (div_num_w),
    .sh_wide (cmd.div_num),
    .den     (t_w),
    .done    (div_done),
    .quo     (div_q)
  );

  qtg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.ev_mul),
    .a     (hacc_r),
    .b     (tau_w),
    .done  (mul_done),
    .prod  (mul_q)
  );

  always_comb begin
    sts.hold       = (tf_r == 32'd0);
    sts.need_solve = (el0 == 32'd0);
    sts.same_t     = (tf_r == t0_r);
    sts.in_range   = (el0 <= tf_r);
    sts.div_done   = div_done;
    sts.mul_done   = mul_done;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= qtg_pkg::PERIOD_RESET;
      pose_r      <= '0;
      vel_r       <= '0;
      acc_r       <= '0;
      elapsed_r   <= '0;
      moving_r    <= 1'b0;
      goal_pose_r <= '0;
      goal_vel_r  <= '0;
      goal_time_r <= '0;
      origin_r    <= '0;
      for (int i = 0; i < 6; i++) coef_r[i] <= '0;
    end else begin
      if (cfg_we) period_r <= cfg_control_period;
      if (cmd.decide) begin
        if (changed) begin
          goal_pose_r <= p1_r;
          goal_vel_r  <= v1_r;
          goal_time_r <= tf_r;
          elapsed_r   <= 32'd0;
        end
        if (sts.hold || (!sts.need_solve && !sts.in_range)) moving_r <= 1'b0;
      end
      if (cmd.solve_init) begin
        coef_r[0] <= {{32{pose_r[31]}}, pose_r} <<< EB;
        coef_r[1] <= v0x <<< EB;
        coef_r[2] <= a0x <<< (EB - 1);
        origin_r  <= t0_r;
      end
      if (cmd.store_coef) coef_r[cmd.k] <= x_r;
      if (cmd.run) begin
        elapsed_r <= esum[32] ? 32'hFFFF_FFFF : esum[31:0];
        moving_r  <= 1'b1;
      end
      if (cmd.ev_store) begin
        unique case (cmd.kind)
          qtg_pkg::KIND_POSE: pose_r <= qtg_pkg::narrow32(hacc_r);
          qtg_pkg::KIND_VEL:  vel_r  <= qtg_pkg::narrow32(hacc_r);
          default:            acc_r  <= qtg_pkg::narrow32(hacc_r);
        endcase
      end
    end
  end

  // working and output registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      p1_r <= in_target_pose;
      v1_r <= in_target_velocity;
      a1_r <= in_target_accel;
      t0_r <= in_start_time;
      tf_r <= in_end_time;
    end
    if (div_done) begin
      x_r <= div_q;
    end else if (cmd.add_term) begin
      x_r <= qtg_pkg::add_sat(x_r, cmd.term_b ? tm_b : tm_a);
    end
    if (cmd.ev_load) begin
      hacc_r <= weight;
    end else if (cmd.ev_add) begin
      hacc_r <= qtg_pkg::add_sat(mul_q, w_r);
    end
    if (cmd.ev_mul) w_r <= weight;
    if (cmd.out_load) begin
      out_pose_out     <= pose_r;
      out_velocity_out <= vel_r;
      out_accel_out    <= acc_r;
      out_moving       <= moving_r;
      out_elapsed_out  <= elapsed_r;
    end
  end

endmodule
`default_nettype wire

### src/qtg_ctrl.sv
// Controller of the quintic trajectory generator: sequences decide, solve,
// evaluate and output steps. Depends on qtg_pkg.
`default_nettype none
module qtg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire qtg_pkg::qtg_sts_t sts,
  output qtg_pkg::qtg_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_SINIT  = 4'd2;
  localparam logic [3:0] S_DGO    = 4'd3;
  localparam logic [3:0] S_DWAIT  = 4'd4;
  localparam logic [3:0] S_ADDT   = 4'd5;
  localparam logic [3:0] S_STORE  = 4'd6;
  localparam logic [3:0] S_RUN    = 4'd7;
  localparam logic [3:0] S_ELOAD  = 4'd8;
  localparam logic [3:0] S_EMUL   = 4'd9;
  localparam logic [3:0] S_EWAIT  = 4'd10;
  localparam logic [3:0] S_ESTORE = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic [2:0] step_r, step_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    step_nxt  = step_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.k     = k_r;
    cmd.kind  = kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        priority if (sts.hold)                     state_nxt = S_FIN;
        else if (sts.need_solve && sts.same_t)     state_nxt = S_FIN;
        else if (sts.need_solve)                   state_nxt = S_SINIT;
        else if (sts.in_range)                     state_nxt = S_RUN;
        else                                       state_nxt = S_FIN;
      end
      S_SINIT: begin
        cmd.solve_init = 1'b1;
        k_nxt     = 3'd3;
        step_nxt  = 3'd0;
        state_nxt = S_DGO;
      end
      S_DGO: begin
        cmd.div_start = 1'b1;
        cmd.div_num   = (step_r == 3'd0);
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          step_nxt = step_r + 3'd1;
          priority if (step_r == 3'd0 || step_r == 3'd2) state_nxt = S_ADDT;
          else if (step_r == k_r + 3'd1)                 state_nxt = S_STORE;
          else                                           state_nxt = S_DGO;
        end
      end
      S_ADDT: begin
        cmd.add_term = 1'b1;
        cmd.term_b   = (step_r == 3'd3);
        step_nxt     = step_r + 3'd1;
        state_nxt    = S_DGO;
      end
      S_STORE: begin
        cmd.store_coef = 1'b1;
        if (k_r == 3'd5) begin
          state_nxt = S_RUN;
        end else begin
          k_nxt     = k_r + 3'd1;
          step_nxt  = 3'd0;
          state_nxt = S_DGO;
        end
      end
      S_RUN: begin
        cmd.run   = 1'b1;
        kind_nxt  = qtg_pkg::KIND_POSE;
        k_nxt     = 3'd5;
        state_nxt = S_ELOAD;
      end
      S_ELOAD: begin
        cmd.ev_load = 1'b1;
        k_nxt       = 3'd4;
        state_nxt   = S_EMUL;
      end
      S_EMUL: begin
        cmd.ev_mul = 1'b1;
        state_nxt  = S_EWAIT;
      end
      S_EWAIT: begin
        if (sts.mul_done) begin
          cmd.ev_add = 1'b1;
          if (k_r == {1'b0, kind_r}) begin
            state_nxt = S_ESTORE;
          end else begin
            k_nxt     = k_r - 3'd1;
            state_nxt = S_EMUL;
          end
        end
      end
      S_ESTORE: begin
        cmd.ev_store = 1'b1;
        if (kind_r == qtg_pkg::KIND_ACC) begin
          state_nxt = S_FIN;
        end else begin
          kind_nxt  = kind_r + 2'd1;
          k_nxt     = 3'd5;
          state_nxt = S_ELOAD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready)        out_valid_nxt = 1'b0;
    else                       out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 3'd0;
      step_r      <= 3'd0;
      kind_r      <= qtg_pkg::KIND_POSE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      step_r      <= step_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### src/quintic_trajectory_generator_unit.sv
// Quintic trajectory generator, one axis, Q16.16. One tick in, one result out.
// A hold tick goes from decide straight to output; an evaluating tick runs 12
// multiplies; a tick that also solves first runs 12 divisions, 4 bits a cycle.
// One tick at a time; the next is taken once its result sits in the output reg.
// Sync active-low reset clears state but not data/output regs; period resets to 66.
`default_nettype none
module quintic_trajectory_generator_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // tick input
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_target_pose,
  input  wire logic signed [31:0] in_target_velocity,
  input  wire logic signed [31:0] in_target_accel,
  input  wire logic [31:0]        in_start_time,
  input  wire logic [31:0]        in_end_time,
  // result
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_pose_out,
  output logic signed [31:0]      out_velocity_out,
  output logic signed [31:0]      out_accel_out,
  output logic                    out_moving,
  output logic [31:0]             out_elapsed_out,
  // control period register
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_control_period
);

  `include "quintic_trajectory_generator_unit_assert.svh"

  qtg_pkg::qtg_cmd_t cmd;
  qtg_pkg::qtg_sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // controller: decide -> optional solve -> optional evaluate -> output
  qtg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: state, coefficient solve (shared divider), Horner (shared multiplier)
  qtg_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_target_pose     (in_target_pose),
    .in_target_velocity (in_target_velocity),
    .in_target_accel    (in_target_accel),
    .in_start_time      (in_start_time),
    .in_end_time        (in_end_time),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_control_period (cfg_control_period),
    .out_pose_out       (out_pose_out),
    .out_velocity_out   (out_velocity_out),
    .out_accel_out      (out_accel_out),
    .out_moving         (out_moving),
    .out_elapsed_out    (out_elapsed_out)
  );

  // at most one state-changing step per cycle
  `QTG_ASSERT_NOW(a_one_step, 1'b1,
    $onehot0({cmd.decide, cmd.solve_init, cmd.run, cmd.ev_load, cmd.ev_store, cmd.out_load}))
  // a tick transfer makes the block busy
  `QTG_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  // the divider never finishes the cycle after it starts
  `QTG_ASSERT_NEXT(a_div_latency, cmd.div_start, !sts.div_done)
  // multiplier results only show up mid-tick
  `QTG_ASSERT_NOW(a_mul_in_tick, sts.mul_done, !in_ready)
  // loading the output register presents a result
  `QTG_ASSERT_NEXT(a_out_loaded, cmd.out_load, out_valid)

endmodule
`default_nettype wire
